// ===== rtl/mqts_pkg.sv =====
package mqts_pkg;

  localparam int unsigned VAL_W = 32;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_STAT = 2'd2;
  // no meaning of its own, answered like a status beat
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } mqts_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] dequeued_value;
    logic signed [VAL_W-1:0] queue_max;
    logic                    queue_empty;
    logic [1:0]              status;
  } mqts_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [VAL_W-1:0] value;
  } mqts_bcast_t;

  function automatic logic signed [VAL_W-1:0] smax(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    smax = (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/mqts_cell.sv =====
module mqts_cell
  import mqts_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                    clk,
  input  mqts_bcast_t             bcast,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [VAL_W-1:0] nbr_val,
  input  logic signed [VAL_W-1:0] nbr_max,
  output logic signed [VAL_W-1:0] val_o,
  output logic signed [VAL_W-1:0] max_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] max_r;

  // max_r holds the max of this entry and every younger one behind it
  always_ff @(posedge clk) begin
    if (bcast.deq) begin
      val_r <= nbr_val;
      max_r <= nbr_max;
    end else if (bcast.enq) begin
      if (count == MY_IDX) begin
        val_r <= bcast.value;
        max_r <= bcast.value;
      end else if (MY_IDX < count) begin
        max_r <= smax(max_r, bcast.value);
      end
    end
  end

  assign val_o = val_r;
  assign max_o = max_r;

endmodule

// ===== rtl/max_queue_two_stacks_top.sv =====
// FIFO of DEPTH signed 32-bit entries that reports its maximum with every beat.
// Each opcode (enqueue, dequeue, status) is completed on acceptance and its result
// sits in an output register, so one item per cycle is sustained while the
// result side keeps up; the input stalls only while a result waits untaken.
// Entries live in a chain of cells with the oldest at cell 0; each cell also
// keeps the max of itself and all younger entries, so a dequeue is one shift
// toward the head and an enqueue is one compare per cell. Full and empty
// cases return an error status and change nothing. No clearing pass is needed
// after reset: only the fill count and the output valid flag are reset.
module max_queue_two_stacks_top
  import mqts_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mqts_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mqts_out_t out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  mqts_out_t        out_data_r, out_data_nxt;
  mqts_bcast_t      bcast;
  logic             acc, is_full, is_empty;

  logic signed [VAL_W-1:0] cval [DEPTH+1];
  logic signed [VAL_W-1:0] cmax [DEPTH+1];

  assign cval[DEPTH] = '0;
  assign cmax[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mqts_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .bcast   (bcast),
      .count   (count_r),
      .nbr_val (cval[i+1]),
      .nbr_max (cmax[i+1]),
      .val_o   (cval[i]),
      .max_o   (cmax[i])
    );
  end

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  always_comb begin
    bcast.enq                   = 1'b0;
    bcast.deq                   = 1'b0;
    bcast.value                 = in_data.value;
    count_nxt                   = count_r;
    out_data_nxt.dequeued_value = '0;
    out_data_nxt.queue_max      = is_empty ? '0 : cmax[0];
    out_data_nxt.status         = ST_OK;
    unique case (in_data.opcode)
      OP_ENQ: begin
        if (is_full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          bcast.enq              = acc;
          count_nxt              = count_r + CNT_ONE;
          out_data_nxt.queue_max = is_empty ? in_data.value : smax(cmax[0], in_data.value);
        end
      end
      OP_DEQ: begin
        if (is_empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          bcast.deq                   = acc;
          count_nxt                   = count_r - CNT_ONE;
          out_data_nxt.dequeued_value = cval[0];
          // head leaves, the next cell's suffix max is the new queue max
          out_data_nxt.queue_max      = (count_r == CNT_ONE) ? '0 : cmax[1];
        end
      end
      default: begin
      end
    endcase
    out_data_nxt.queue_empty = (count_nxt == '0);
  end

  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("fill count above depth");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_data.opcode == OP_ENQ) && is_full |=> $stable(count_r))
    else $error("enqueue on full queue changed the count");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_data.opcode == OP_DEQ) && !is_empty |=> count_r == $past(count_r) - CNT_ONE)
    else $error("dequeue did not drop the count by one");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_data_r.queue_empty == (count_r == '0))
    else $error("empty flag disagrees with fill count");
`endif

endmodule
